FILE: design/cco_pkg.sv
// ----------------------------------------------------------------------------
// Chua oscillator package
// Shared widths, constants, codes, the controller/datapath interface structs
// and the saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package cco_pkg;

  // Widths of the state, the configuration and the result fields.
  localparam int STATE_W = 40;
  localparam int MAX_SUB = 64;
  localparam int SUB_W   = $clog2(MAX_SUB + 1);
  localparam int RATE_W  = 21;
  localparam int COEF_W  = 32;
  localparam int CFG_W   = 32;
  localparam int ADDR_W  = 3;
  localparam int OUT_W   = 18;

  // Sequential divider operand widths.
  localparam int NUM_W = 50;
  localparam int DEN_W = 30;

  // Fixed-point constants (state is Q.32).
  localparam logic signed [63:0] MAX64   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN64   = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ST_MAX  = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
  localparam logic signed [63:0] ST_MIN  = -ST_MAX - 64'sd1;
  localparam logic signed [63:0] X_INIT  = 64'sd429496730;
  localparam logic signed [63:0] ONE_Q32 = 64'sd4294967296;
  localparam logic signed [63:0] LIM_Q32 = 64'sd85899345920;
  localparam logic [16:0]        OUT_ONE = 17'd65536;
  // z output divides by 7: cap the operand at 7 * 65536, then multiply by
  // ceil(2^22 / 7) and shift right by 22, which is exact over that range.
  localparam logic [18:0]        Z_CAP   = 19'd458752;
  localparam logic [19:0]        RECIP7  = 20'd599187;
  localparam logic [10:0]        N_SCALE = 11'd1500;

  // Configuration register indexes.
  typedef enum logic [ADDR_W-1:0] {
    CFG_ALPHA = 3'd0,
    CFG_BETA  = 3'd1,
    CFG_M0    = 3'd2,
    CFG_M1    = 3'd3,
    CFG_SPEED = 3'd4,
    CFG_RATE  = 3'd5
  } cfg_idx_t;

  // Multiplications of one Euler substep, in issue order.
  typedef enum logic [2:0] {
    OP_FO = 3'd0,
    OP_FD = 3'd1,
    OP_DX = 3'd2,
    OP_DZ = 3'd3,
    OP_UX = 3'd4,
    OP_UY = 3'd5,
    OP_UZ = 3'd6
  } op_sel_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] alpha;
    logic signed [COEF_W-1:0] beta;
    logic signed [COEF_W-1:0] m0;
    logic signed [COEF_W-1:0] m1;
    logic [COEF_W-1:0]        speed;
    logic [RATE_W-1:0]        rate;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    accept;
    logic    set_n;
    logic    h_go;
    logic    set_h;
    logic    mul_go;
    logic    mul_take;
    logic    step;
    logic    clamp;
    logic    emit;
    op_sel_t sel;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic last_step;
    logic out_free;
  } stat_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? MIN64 : MAX64;
    else sat_add = s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    sat_neg = (a == MIN64) ? MAX64 : -a;
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
    clamp64 = (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = clamp64(v, ST_MIN, ST_MAX);
    sat_state = c[STATE_W-1:0];
  endfunction

endpackage

FILE: design/chua_chaos_oscillator.sv
// ----------------------------------------------------------------------------
// Chua chaotic oscillator
// Explicit Euler integration of the Chua circuit, one audio sample per word.
// ----------------------------------------------------------------------------
// Usage: each word on the in_ stream (bit 0 = reset level) produces one word
// on the out_ stream holding x/2, y/0.5 and z/3.5 in signed Q1.16.
// A rising reset level restores x = 0.1, y = z = 0 before the sample.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must
// write them only while idle, the block itself does not enforce it.
// Each word runs two divisions (substep count and length), then n
// substeps of seven multiplications in the shared 32 x 32 multiplier plus
// an update each, then a clamp and the emit of the result, n from 1 to 64
// (n = 1 at the default speed and rate). The next word can be accepted
// in the same cycle as the result becomes valid.
// One word is in work at a time; in_tready is high only while idle.
// The result register lets the next word be accepted while a result waits;
// a stalled receiver holds the block before it emits the following result.
// Reset (rst_n low, synchronous) restores all registers to their defaults
// and the initial oscillator state; no output is valid after reset.
module chua_chaos_oscillator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] reset_level, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [17:0] x_out, [35:18] y_out, [53:36] z_out
  input  logic        cfg_we,
  input  logic [cco_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [cco_pkg::CFG_W-1:0]  cfg_wdata
);
  import cco_pkg::*;

  cfg_t             cfg_r;
  cmd_t             cmd;
  stat_t            stat;
  logic [OUT_W-1:0] x_out, y_out, z_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha <= 32'sd261724570;
      cfg_r.beta  <= 32'sd469762048;
      cfg_r.m0    <= -32'sd19176358;
      cfg_r.m1    <= -32'sd11978932;
      cfg_r.speed <= 32'd16777216;
      cfg_r.rate  <= 21'd48000;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ALPHA: cfg_r.alpha <= cfg_wdata;
        CFG_BETA:  cfg_r.beta  <= cfg_wdata;
        CFG_M0:    cfg_r.m0    <= cfg_wdata;
        CFG_M1:    cfg_r.m1    <= cfg_wdata;
        CFG_SPEED: cfg_r.speed <= cfg_wdata;
        CFG_RATE:  cfg_r.rate  <= cfg_wdata[RATE_W-1:0];
        default:   ;
      endcase
    end
  end

  cco_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  cco_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .reset_level(in_tdata[0]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .x_out      (x_out),
    .y_out      (y_out),
    .z_out      (z_out)
  );

  assign out_tdata = {2'b00, z_out, y_out, x_out};

`ifndef SYNTHESIS
  // Only one word is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted while another is in work");

  // Emitted x stays within plus or minus one.
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[17:0]) <= 18'sd65536 &&
                    $signed(out_tdata[17:0]) >= -18'sd65536))
    else $error("x_out out of range");

  // No result is valid right after reset.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
`endif

endmodule

FILE: design/cco_div.sv
// ----------------------------------------------------------------------------
// Chua oscillator divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cco_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [cco_pkg::NUM_W-1:0] num,
  input  logic [cco_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [cco_pkg::NUM_W-1:0] quo
);
  import cco_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   shl;
  logic [DEN_W+1:0] diff;

  // Trial subtraction of the divisor from the shifted remainder.
  assign shl  = {rem_r, quo_r[NUM_W-1]};
  assign diff = {1'b0, shl} - {2'b00, den_r};

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift.
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      if (!diff[DEN_W+1]) begin
        rem_r <= diff[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= shl[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: design/cco_mul.sv
// ----------------------------------------------------------------------------
// Chua oscillator multiplier
// Signed 64 x 64 multiply over four 32 x 32 partial products, then a shift
// right by 24 or 40 truncating toward zero, saturated to 64 bits.
// ----------------------------------------------------------------------------
module cco_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic               sh40,
  output logic               done,
  output logic signed [63:0] res
);
  import cco_pkg::*;

  logic [63:0]        ua_r;
  logic [63:0]        ub_r;
  logic               neg_r;
  logic               sh40_r;
  logic [2:0]         cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [63:0]        pp_r;
  logic [1:0]         off_r;
  logic [127:0]       acc_r;
  logic signed [63:0] res_r;
  logic [31:0]        pa;
  logic [31:0]        pb;
  logic [127:0]       pp_sh;
  logic [127:0]       acc_sh;
  logic               ovf;

  // Word selection for the current partial product.
  assign pa = cnt_r[1] ? ua_r[63:32] : ua_r[31:0];
  assign pb = cnt_r[0] ? ub_r[63:32] : ub_r[31:0];

  always_comb begin
    unique case (off_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
  end

  assign acc_sh = sh40_r ? (acc_r >> 40) : (acc_r >> 24);
  assign ovf    = |acc_sh[127:63];

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands, partial products, accumulation and final shift.
  always_ff @(posedge clk) begin
    if (go) begin
      ua_r   <= a[63] ? 64'(-a) : 64'(a);
      ub_r   <= b[63] ? 64'(-b) : 64'(b);
      neg_r  <= a[63] ^ b[63];
      sh40_r <= sh40;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r <= 3'd3) begin
        pp_r  <= 64'(pa) * 64'(pb);
        off_r <= 2'(cnt_r[1]) + 2'(cnt_r[0]);
      end
      if (cnt_r >= 3'd1 && cnt_r <= 3'd4) acc_r <= acc_r + pp_sh;
      if (cnt_r == 3'd5) begin
        if (neg_r) res_r <= ovf ? MIN64 : -$signed(acc_sh[63:0]);
        else res_r <= ovf ? MAX64 : $signed(acc_sh[63:0]);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: design/cco_ctrl.sv
// ----------------------------------------------------------------------------
// Chua oscillator controller
// Sequences the substep count and length divisions, the seven
// multiplications of each Euler substep, the final clamp and the result.
// ----------------------------------------------------------------------------
module cco_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cco_pkg::stat_t stat,
  output cco_pkg::cmd_t  cmd
);
  import cco_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIVN  = 9'b000000010,
    S_HGO   = 9'b000000100,
    S_DIVH  = 9'b000001000,
    S_MGO   = 9'b000010000,
    S_MWAIT = 9'b000100000,
    S_STEP  = 9'b001000000,
    S_CLAMP = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t  state_r, state_nxt;
  op_sel_t sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= OP_FO;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd       = '0;
    cmd.sel   = sel_r;
    state_nxt = state_r;
    sel_nxt   = sel_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DIVN;
        end
      end
      S_DIVN: begin
        if (stat.div_done) begin
          cmd.set_n = 1'b1;
          state_nxt = S_HGO;
        end
      end
      S_HGO: begin
        cmd.h_go  = 1'b1;
        state_nxt = S_DIVH;
      end
      S_DIVH: begin
        if (stat.div_done) begin
          cmd.set_h = 1'b1;
          sel_nxt   = OP_FO;
          state_nxt = S_MGO;
        end
      end
      S_MGO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.mul_done) begin
          cmd.mul_take = 1'b1;
          if (sel_r == OP_UZ) begin
            state_nxt = S_STEP;
          end else begin
            sel_nxt   = op_sel_t'(sel_r + 3'd1);
            state_nxt = S_MGO;
          end
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        sel_nxt  = OP_FO;
        state_nxt = stat.last_step ? S_CLAMP : S_MGO;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/cco_datapath.sv
// ----------------------------------------------------------------------------
// Chua oscillator datapath
// Holds the oscillator state, the substep count and length, the substep
// intermediates and the result register; owns the divider and multiplier.
// ----------------------------------------------------------------------------
module cco_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cco_pkg::cfg_t             cfg,
  input  logic                      reset_level,
  input  cco_pkg::cmd_t             cmd,
  output cco_pkg::stat_t            stat,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [cco_pkg::OUT_W-1:0] x_out,
  output logic [cco_pkg::OUT_W-1:0] y_out,
  output logic [cco_pkg::OUT_W-1:0] z_out
);
  import cco_pkg::*;

  logic signed [STATE_W-1:0] x_r, y_r, z_r;
  logic                      reset_prev_r;
  logic [RATE_W-1:0]         rate_r;
  logic [SUB_W-1:0]          n_r;
  logic [SUB_W-1:0]          cnt_r;
  logic [NUM_W-1:0]          h_r;
  logic signed [63:0]        p1_r, f_r, dx_r, dz_r, ux_r, uy_r, uz_r;
  logic                      out_valid_r;
  logic [OUT_W-1:0]          x_out_r, y_out_r, z_out_r;

  logic signed [63:0] x64, y64, z64, cx, dm, dxin, dy, h64;
  logic signed [63:0] mul_a, mul_b, mul_res;
  logic               mul_sh40, mul_done;
  logic               div_go, div_done;
  logic [NUM_W-1:0]   div_num, div_quo;
  logic [DEN_W-1:0]   div_den;
  logic [RATE_W-1:0]  rate_eff;
  logic [42:0]        n_prod;
  logic [27:0]        rn;
  logic [DEN_W-1:0]   den_h;
  logic [NUM_W-1:0]   num_h;
  logic [STATE_W-1:0] xm, ym, zm;
  logic [STATE_W-1:0] xs, ys, zs;
  logic [16:0]        xc, yc, zc;
  logic [18:0]        zcap;
  logic [38:0]        zprod;

  assign x64 = 64'(x_r);
  assign y64 = 64'(y_r);
  assign z64 = 64'(z_r);
  assign h64 = $signed({{(64 - NUM_W){1'b0}}, h_r});

  // Substep terms.
  assign cx   = clamp64(x64, -ONE_Q32, ONE_Q32);
  assign dm   = 64'(cfg.m0) - 64'(cfg.m1);
  assign dxin = sat_add(sat_add(y64, sat_neg(x64)), sat_neg(f_r));
  assign dy   = sat_add(sat_add(x64, sat_neg(y64)), z64);

  // Multiplier operand selection.
  always_comb begin
    unique case (cmd.sel)
      OP_FO:   begin mul_a = 64'(cfg.m1);    mul_b = x64;  mul_sh40 = 1'b0; end
      OP_FD:   begin mul_a = dm;             mul_b = cx;   mul_sh40 = 1'b0; end
      OP_DX:   begin mul_a = 64'(cfg.alpha); mul_b = dxin; mul_sh40 = 1'b0; end
      OP_DZ:   begin mul_a = 64'(cfg.beta);  mul_b = y64;  mul_sh40 = 1'b0; end
      OP_UX:   begin mul_a = dx_r;           mul_b = h64;  mul_sh40 = 1'b1; end
      OP_UY:   begin mul_a = dy;             mul_b = h64;  mul_sh40 = 1'b1; end
      OP_UZ:   begin mul_a = dz_r;           mul_b = h64;  mul_sh40 = 1'b1; end
      default: begin mul_a = '0;             mul_b = '0;   mul_sh40 = 1'b0; end
    endcase
  end

  cco_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .sh40 (mul_sh40),
    .done (mul_done),
    .res  (mul_res)
  );

  // Divider operands: substep count first, then substep length.
  assign rate_eff = (cfg.rate == '0) ? RATE_W'(1) : cfg.rate;
  assign n_prod   = 43'(cfg.speed) * 43'(N_SCALE);
  assign rn       = 28'(rate_r) * 28'(n_r);
  assign den_h    = DEN_W'({rn, 2'b00}) + DEN_W'(rn);
  assign num_h    = (NUM_W'(cfg.speed) << 17) + (NUM_W'(cfg.speed) << 16);
  assign div_go   = cmd.accept | cmd.h_go;
  assign div_num  = cmd.accept ? NUM_W'(n_prod[42:24]) : num_h;
  assign div_den  = cmd.accept ? DEN_W'(rate_eff) : den_h;

  cco_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Result scaling: x/2^17, y/2^15 and 2z/(7*2^16), toward zero, clamped to one.
  assign xm   = x_r[STATE_W-1] ? STATE_W'(-x_r) : STATE_W'(x_r);
  assign ym   = y_r[STATE_W-1] ? STATE_W'(-y_r) : STATE_W'(y_r);
  assign zm   = z_r[STATE_W-1] ? STATE_W'(-z_r) : STATE_W'(z_r);
  assign xs   = xm >> 17;
  assign ys   = ym >> 15;
  assign zs   = zm >> 15;
  assign xc   = (xs > STATE_W'(OUT_ONE)) ? OUT_ONE : xs[16:0];
  assign yc   = (ys > STATE_W'(OUT_ONE)) ? OUT_ONE : ys[16:0];
  assign zcap = (zs > STATE_W'(Z_CAP)) ? Z_CAP : zs[18:0];
  assign zprod = 39'(zcap) * 39'(RECIP7);
  assign zc   = zprod[38:22];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_prev_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.accept) reset_prev_r <= reset_level;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Oscillator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= STATE_W'(X_INIT);
      y_r <= '0;
      z_r <= '0;
    end else if (cmd.accept) begin
      if (reset_level && !reset_prev_r) begin
        x_r <= STATE_W'(X_INIT);
        y_r <= '0;
        z_r <= '0;
      end
    end else if (cmd.step) begin
      x_r <= sat_state(sat_add(x64, ux_r));
      y_r <= sat_state(sat_add(y64, uy_r));
      z_r <= sat_state(sat_add(z64, uz_r));
    end else if (cmd.clamp) begin
      x_r <= sat_state(clamp64(x64, -LIM_Q32, LIM_Q32));
      y_r <= sat_state(clamp64(y64, -LIM_Q32, LIM_Q32));
      z_r <= sat_state(clamp64(z64, -LIM_Q32, LIM_Q32));
    end
  end

  // Substep count, length and counter.
  always_ff @(posedge clk) begin
    if (cmd.accept) rate_r <= rate_eff;
    if (cmd.set_n) begin
      if (div_quo == '0) n_r <= SUB_W'(1);
      else if (div_quo > NUM_W'(MAX_SUB)) n_r <= SUB_W'(MAX_SUB);
      else n_r <= div_quo[SUB_W-1:0];
    end
    if (cmd.set_h) begin
      h_r   <= div_quo;
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Multiplier results.
  always_ff @(posedge clk) begin
    if (cmd.mul_take) begin
      unique case (cmd.sel)
        OP_FO:   p1_r <= mul_res;
        OP_FD:   f_r  <= sat_add(p1_r, mul_res);
        OP_DX:   dx_r <= mul_res;
        OP_DZ:   dz_r <= sat_neg(mul_res);
        OP_UX:   ux_r <= mul_res;
        OP_UY:   uy_r <= mul_res;
        OP_UZ:   uz_r <= mul_res;
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      x_out_r <= x_r[STATE_W-1] ? -{1'b0, xc} : {1'b0, xc};
      y_out_r <= y_r[STATE_W-1] ? -{1'b0, yc} : {1'b0, yc};
      z_out_r <= z_r[STATE_W-1] ? -{1'b0, zc} : {1'b0, zc};
    end
  end

  assign stat.div_done  = div_done;
  assign stat.mul_done  = mul_done;
  assign stat.last_step = (cnt_r == n_r - 1'b1);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign x_out     = x_out_r;
  assign y_out     = y_out_r;
  assign z_out     = z_out_r;

endmodule
